// ===== rtl/sound_voice_allocator_unit_macros.svh =====
// Assertion macros for the voice allocator.
// Included by the top level; no other dependencies.
`ifndef SOUND_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define SOUND_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define SVAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voice allocator check failed");
`define SVAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voice allocator check failed");
`else
`define SVAU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SVAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sva_pkg.sv =====
// Shared types, codes and helpers for the voice allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sva_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TREAD,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } sva_state_t;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_BAD_TYPE = 3'd1;
    localparam logic [2:0] STAT_REPEAT   = 3'd2;
    localparam logic [2:0] STAT_NO_VOICE = 3'd3;
    localparam logic [2:0] STAT_BAD_SLOT = 3'd4;
    localparam logic [2:0] STAT_RELEASED = 3'd5;

    localparam logic [2:0] CFG_CAPACITY = 3'd0;
    localparam logic [2:0] CFG_ORD_LIMIT = 3'd1;
    localparam logic [2:0] CFG_REUSE_DLY = 3'd2;
    localparam logic [2:0] CFG_REPEAT_WIN = 3'd3;
    localparam logic [2:0] CFG_PRI_MAP = 3'd4;

    typedef struct packed {
        logic load_item;
        logic type_read;
        logic check_finish;
        logic scan_start;
        logic scan_issue;
        logic decide_finish;
    } sva_cmd_t;

    typedef struct packed {
        logic check_final;
        logic cap_zero;
        logic issue_last;
        logic out_free;
    } sva_stat_t;

    // priority code 3 counts as 2
    function automatic logic [1:0] pri_of(input logic [63:0] pmap, input logic [4:0] t);
        logic [1:0] p;
        p = pmap[{t, 1'b0} +: 2];
        return (p == 2'd3) ? 2'd2 : p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sva_item_if.sv =====
// Request channel: acquire/release items.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sva_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [4:0]  sound_type;
    logic [4:0]  slot;
    logic [31:0] now_ms;

    modport source (output valid, command, sound_type, slot, now_ms, input ready);
    modport sink (input valid, command, sound_type, slot, now_ms, output ready);
endinterface
`default_nettype wire

// ===== rtl/sva_result_if.sv =====
// Result channel: grant, voice index and status.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sva_result_if;
    logic       valid;
    logic       ready;
    logic       granted;
    logic [3:0] voice_index;
    logic [2:0] status;

    modport source (output valid, granted, voice_index, status, input ready);
    modport sink (input valid, granted, voice_index, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/sva_cfg_if.sv =====
// Configuration write channel: register index and data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sva_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sound_voice_allocator_unit.sv =====
// Top level of the voice allocator: sequencer, datapath, channel wiring.
// Depends on sva_pkg, the channel interfaces, sva_ctrl and sva_datapath.
//
//  channel  | dir | payload                                  | transfer when
//  ---------+-----+------------------------------------------+---------------
//  item     | in  | command, sound_type, slot, now_ms        | valid & ready
//  result   | out | granted, voice_index, status             | valid & ready
//  cfg      | in  | index (register number), data            | valid & ready
//
// Acquire: TREAD, CHECK, SCAN, DRAIN, DECIDE; the scan reads one voice per
// cycle through the read ports of the start and reuse RAMs.
// Release and rejected acquires end in CHECK; zero capacity skips to DECIDE.
// Reset clears voice and type flags and loads register defaults; no clearing pass.
// A waiting result does not block the next item transfer; a full result
// register stalls only the final step of the following item.
`timescale 1ns / 1ps
`default_nettype none
`include "sound_voice_allocator_unit_macros.svh"
module sound_voice_allocator_unit #(
    parameter int MAX_VOICES = 16,
    parameter int NUM_TYPES  = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    sva_item_if.sink           item,
    sva_result_if.source       result,
    sva_cfg_if.sink            cfg
);
    import sva_pkg::*;

    sva_cmd_t  cmd;
    sva_stat_t st;

    assign cfg.ready = 1'b1;

    sva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .st       (st),
        .cmd      (cmd)
    );

    sva_datapath #(
        .MAX_VOICES (MAX_VOICES),
        .NUM_TYPES  (NUM_TYPES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .in_command      (item.command),
        .in_sound_type   (item.sound_type),
        .in_slot         (item.slot),
        .in_now_ms       (item.now_ms),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_granted     (result.granted),
        .out_voice_index (result.voice_index),
        .out_status      (result.status)
    );

    `SVAU_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, item.valid && item.ready, !item.ready)
    `SVAU_ASSERT_NOW(a_grant_is_ok, clk, rst_n, result.valid && result.granted, result.status == STAT_OK)
    `SVAU_ASSERT_NOW(a_no_grant_zero_idx, clk, rst_n,
        result.valid && !result.granted, result.voice_index == 4'd0)
    `SVAU_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.check_finish || cmd.decide_finish, st.out_free)
endmodule
`default_nettype wire

// ===== rtl/sva_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sva_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sva_ctrl.sv =====
// Sequencer for the voice allocator: check, scan, decide.
// Depends on sva_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sva_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sva_pkg::sva_stat_t st,
    output sva_pkg::sva_cmd_t       cmd
);
    import sva_pkg::*;

    sva_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_TREAD;
                end
            end
            S_TREAD:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (st.check_final)
                begin
                    if (st.out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (st.cap_zero)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            S_TREAD:
            begin
                cmd.type_read = 1'b1;
            end
            S_CHECK:
            begin
                cmd.check_finish = st.check_final && st.out_free;
                cmd.scan_start   = !st.check_final;
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            S_DRAIN:
            begin
                cmd = '0;
            end
            S_DECIDE:
            begin
                cmd.decide_finish = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/sva_datapath.sv =====
// Voice tables, config registers, scan trackers and result register.
// Depends on sva_pkg and sva_ram.
`timescale 1ns / 1ps
`default_nettype none
module sva_datapath #(
    parameter int MAX_VOICES = 16,
    parameter int NUM_TYPES  = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sva_pkg::sva_cmd_t  cmd,
    output sva_pkg::sva_stat_t      st,
    input  wire logic               in_command,
    input  wire logic [4:0]         in_sound_type,
    input  wire logic [4:0]         in_slot,
    input  wire logic [31:0]        in_now_ms,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    out_granted,
    output logic [3:0]              out_voice_index,
    output logic [2:0]              out_status
);
    import sva_pkg::*;

    localparam int VW      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int TW      = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int CW      = $clog2(MAX_VOICES + 1);
    localparam int CMPW    = CW + 5;
    localparam int CAP_RST = (MAX_VOICES < 16) ? MAX_VOICES : 16;

    // configuration
    logic [CW-1:0] cap_reg, cap_next;
    logic [CW-1:0] ord_reg, ord_next;
    logic [15:0]   reuse_dly_reg;
    logic [15:0]   window_reg;
    logic [63:0]   pmap_reg;
    logic [4:0]    cfg_v5;
    logic [CW-1:0] cap_clip;

    // latched item
    logic          command_reg;
    logic [4:0]    type_reg;
    logic [4:0]    slot_reg;
    logic [31:0]   now_reg;

    // per-voice and per-type flags
    logic [MAX_VOICES-1:0] active_reg, active_next;
    logic [MAX_VOICES-1:0] stamped_reg, stamped_next;
    logic [NUM_TYPES-1:0]  started_reg, started_next;

    // scan
    logic [VW-1:0] issue_idx_reg;
    logic [VW-1:0] eval_idx_reg;
    logic          rd_valid_reg;
    logic          free_found_reg, free_found_next;
    logic [VW-1:0] free_idx_reg, free_idx_next;
    logic          steal_found_reg, steal_found_next;
    logic [VW-1:0] steal_idx_reg, steal_idx_next;
    logic [31:0]   oldest_reg, oldest_next;

    // memories
    logic [31:0]    last_start;
    logic [TW+31:0] start_rdata;
    logic [31:0]    reuse_rdata;
    logic           start_we;
    logic           reuse_we;
    logic [32:0]    reuse_sum;
    logic [31:0]    reuse_sat;

    // derived
    logic [TW-1:0] tidx;
    logic          type_bad;
    logic          slot_bad;
    logic          repeat_hit;
    logic [1:0]    req_pri;
    logic [CW-1:0] limit;
    logic          is_release;
    logic [2:0]    check_code;
    logic          v_active;
    logic [31:0]   v_reuse;
    logic [31:0]   v_start;
    logic [TW-1:0] v_type;
    logic          free_hit;
    logic          steal_hit;
    logic          grant;
    logic [VW-1:0] pick;
    logic          out_load;

    // ---------------- configuration ----------------
    assign cfg_v5   = cfg_data[4:0];
    assign cap_clip = (CMPW'(cfg_v5) > CMPW'(MAX_VOICES)) ? CW'(MAX_VOICES) : CW'(cfg_v5);

    always_comb
    begin
        cap_next = cap_reg;
        ord_next = ord_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAPACITY:
                begin
                    cap_next = cap_clip;
                    if (ord_reg > cap_clip)
                    begin
                        ord_next = cap_clip;
                    end
                end
                CFG_ORD_LIMIT:
                begin
                    ord_next = (CMPW'(cfg_v5) > CMPW'(cap_reg)) ? cap_reg : CW'(cfg_v5);
                end
                default:
                begin
                    cap_next = cap_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CW'(CAP_RST);
            ord_reg       <= CW'(CAP_RST);
            reuse_dly_reg <= '0;
            window_reg    <= '0;
            pmap_reg      <= '0;
        end
        else
        begin
            cap_reg <= cap_next;
            ord_reg <= ord_next;
            if (cfg_we && cfg_index == CFG_REUSE_DLY)
            begin
                reuse_dly_reg <= cfg_data[15:0];
            end
            if (cfg_we && cfg_index == CFG_REPEAT_WIN)
            begin
                window_reg <= cfg_data[15:0];
            end
            if (cfg_we && cfg_index == CFG_PRI_MAP)
            begin
                pmap_reg <= cfg_data;
            end
        end
    end

    // ---------------- item latch ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            command_reg <= in_command;
            type_reg    <= in_sound_type;
            slot_reg    <= in_slot;
            now_reg     <= in_now_ms;
        end
    end

    // ---------------- checks ----------------
    assign tidx       = TW'(type_reg);
    assign is_release = (command_reg == CMD_RELEASE);
    assign type_bad   = (6'(type_reg) >= 6'(NUM_TYPES));
    assign slot_bad   = (CMPW'(slot_reg) >= CMPW'(cap_reg));
    assign repeat_hit = started_reg[tidx] && (now_reg >= last_start)
                        && ((now_reg - last_start) < {16'd0, window_reg});
    assign req_pri    = pri_of(pmap_reg, type_reg);
    assign limit      = (req_pri != 2'd0) ? cap_reg : ord_reg;

    always_comb
    begin
        if (is_release)
        begin
            check_code = slot_bad ? STAT_BAD_SLOT : STAT_RELEASED;
        end
        else if (type_bad)
        begin
            check_code = STAT_BAD_TYPE;
        end
        else
        begin
            check_code = STAT_REPEAT;
        end
    end

    assign reuse_sum = {1'b0, now_reg} + {17'd0, reuse_dly_reg};
    assign reuse_sat = reuse_sum[32] ? 32'hFFFF_FFFF : reuse_sum[31:0];
    assign reuse_we  = cmd.check_finish && is_release && !slot_bad;

    // ---------------- scan ----------------
    assign v_active = active_reg[eval_idx_reg];
    assign v_reuse  = stamped_reg[eval_idx_reg] ? reuse_rdata : 32'd0;
    assign v_start  = start_rdata[31:0];
    assign v_type   = start_rdata[TW+31:32];

    assign free_hit  = rd_valid_reg && !v_active && (now_reg >= v_reuse)
                       && (CW'(eval_idx_reg) < limit);
    assign steal_hit = rd_valid_reg && v_active && (pri_of(pmap_reg, 5'(v_type)) < req_pri)
                       && (!steal_found_reg || v_start < oldest_reg);

    always_comb
    begin
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        steal_found_next = steal_found_reg;
        steal_idx_next   = steal_idx_reg;
        oldest_next      = oldest_reg;
        if (cmd.scan_start)
        begin
            free_found_next  = 1'b0;
            steal_found_next = 1'b0;
        end
        else
        begin
            // keep the lowest free index only
            if (free_hit && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = eval_idx_reg;
            end
            if (steal_hit)
            begin
                steal_found_next = 1'b1;
                steal_idx_next   = eval_idx_reg;
                oldest_next      = v_start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg    <= 1'b0;
            free_found_reg  <= 1'b0;
            steal_found_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg    <= cmd.scan_issue;
            free_found_reg  <= free_found_next;
            steal_found_reg <= steal_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg  <= free_idx_next;
        steal_idx_reg <= steal_idx_next;
        oldest_reg    <= oldest_next;
        eval_idx_reg  <= issue_idx_reg;
        if (cmd.scan_start)
        begin
            issue_idx_reg <= '0;
        end
        else if (cmd.scan_issue)
        begin
            issue_idx_reg <= issue_idx_reg + VW'(1);
        end
    end

    // ---------------- decide ----------------
    assign grant    = free_found_reg || ((req_pri != 2'd0) && steal_found_reg);
    assign pick     = free_found_reg ? free_idx_reg : steal_idx_reg;
    assign start_we = cmd.decide_finish && grant;

    always_comb
    begin
        active_next  = active_reg;
        stamped_next = stamped_reg;
        started_next = started_reg;
        if (reuse_we)
        begin
            active_next[VW'(slot_reg)]  = 1'b0;
            stamped_next[VW'(slot_reg)] = 1'b1;
        end
        if (start_we)
        begin
            active_next[pick]  = 1'b1;
            started_next[tidx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            stamped_reg <= '0;
            started_reg <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            stamped_reg <= stamped_next;
            started_reg <= started_next;
        end
    end

    // ---------------- memories ----------------
    sva_ram #(
        .WIDTH (32),
        .DEPTH (NUM_TYPES)
    ) u_type_ram (
        .clk   (clk),
        .we    (start_we),
        .waddr (tidx),
        .wdata (now_reg),
        .re    (cmd.type_read),
        .raddr (tidx),
        .rdata (last_start)
    );

    sva_ram #(
        .WIDTH (TW + 32),
        .DEPTH (MAX_VOICES)
    ) u_start_ram (
        .clk   (clk),
        .we    (start_we),
        .waddr (pick),
        .wdata ({tidx, now_reg}),
        .re    (cmd.scan_issue),
        .raddr (issue_idx_reg),
        .rdata (start_rdata)
    );

    sva_ram #(
        .WIDTH (32),
        .DEPTH (MAX_VOICES)
    ) u_reuse_ram (
        .clk   (clk),
        .we    (reuse_we),
        .waddr (VW'(slot_reg)),
        .wdata (reuse_sat),
        .re    (cmd.scan_issue),
        .raddr (issue_idx_reg),
        .rdata (reuse_rdata)
    );

    // ---------------- result register ----------------
    assign out_load = cmd.check_finish || cmd.decide_finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check_finish)
        begin
            out_granted     <= 1'b0;
            out_voice_index <= 4'd0;
            out_status      <= check_code;
        end
        else if (cmd.decide_finish)
        begin
            out_granted     <= grant;
            out_voice_index <= grant ? 4'(pick) : 4'd0;
            out_status      <= grant ? STAT_OK : STAT_NO_VOICE;
        end
    end

    // ---------------- status ----------------
    assign st.check_final = is_release || type_bad || repeat_hit;
    assign st.cap_zero    = (cap_reg == '0);
    assign st.issue_last  = (CW'(issue_idx_reg) == cap_reg - CW'(1));
    assign st.out_free    = !out_valid || out_ready;
endmodule
`default_nettype wire
